[hw/rtl/mbcd_pkg.sv]
// Shared types and constants for the 4x4 matrix block decoder.
// Holds the key digit table and the cofactor function; no dependencies.
package mbcd_pkg;

    localparam int DIM     = 4;
    localparam int CIP_W   = 14;
    localparam int COF_W   = 14;  // |3x3 minor| <= 4374
    localparam int DET_W   = 19;  // |det| <= 157464
    localparam int PROD_W  = 28;  // 14b unsigned * 14b signed, bounded by 2^27
    localparam int NUM_W   = 30;  // sum of four products
    localparam int DIVN_W  = 30;  // 2|num| + |det|
    localparam int DIVD_W  = 19;  // 2|det|
    localparam int QB      = 17;  // quotient bits kept before clamping
    localparam int OUT_W   = 16;
    localparam int LATENCY = 23;  // start edge to result edge

    typedef logic [3:0]                 t_digit;
    typedef logic [DIM-1:0][DIM-1:0][3:0] t_key;
    typedef logic signed [COF_W-1:0]    t_cof;

    localparam t_digit KEY_TABLE [0:7][0:DIM-1] = '{
        '{4'd8, 4'd1, 4'd8, 4'd9}, '{4'd5, 4'd5, 4'd0, 4'd9},
        '{4'd6, 4'd3, 4'd3, 4'd1}, '{4'd5, 4'd4, 4'd5, 4'd4},
        '{4'd8, 4'd0, 4'd4, 4'd3}, '{4'd8, 4'd9, 4'd9, 4'd0},
        '{4'd1, 4'd9, 4'd7, 4'd2}, '{4'd0, 4'd7, 4'd3, 4'd4}
    };

    // Signed cofactor of entry (rr, cc): small digits, so plain products
    function automatic t_cof cofactor(input t_key k, input int unsigned rr,
                                      input int unsigned cc);
        logic signed [5:0]  s [0:2][0:2];
        logic signed [16:0] m;
        int unsigned        sr;
        int unsigned        sc;
        sr = 0;
        for (int unsigned r = 0; r < DIM; r++) begin
            if (r != rr) begin
                sc = 0;
                for (int unsigned c = 0; c < DIM; c++) begin
                    if (c != cc) begin
                        s[sr[1:0]][sc[1:0]] = signed'({2'b00, k[r][c]});
                        sc++;
                    end
                end
                sr++;
            end
        end
        m = s[0][0] * (s[1][1] * s[2][2] - s[2][1] * s[1][2])
          - s[0][1] * (s[1][0] * s[2][2] - s[2][0] * s[1][2])
          + s[0][2] * (s[1][0] * s[2][1] - s[2][0] * s[1][1]);
        if (((rr + cc) & 1) != 0) begin
            m = -m;
        end
        return m[COF_W-1:0];
    endfunction

endpackage

[hw/rtl/matrix_block_cipher_decode_top.sv]
// Top level of the 4x4 matrix block decoder: front end plus four divider lanes.
// Depends on mbcd_pkg, mbcd_front and mbcd_div.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     start, busy          i_cipher_0..3, i_row_code_0..3
//  result    o_valid (strobe)     o_plain_0..3, o_singular
//
// One item per cycle; busy is always low. Each result passes through four front
// stages, the divider entry stage, 17 quotient
// stages and the clamp stage.
// Reset clears only the valid bits; no clearing pass is needed.
// Results are shown for exactly one cycle; nothing in the pipe ever waits.
module matrix_block_cipher_decode_top import mbcd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CIP_W-1:0]         i_cipher_0,
    input  logic [CIP_W-1:0]         i_cipher_1,
    input  logic [CIP_W-1:0]         i_cipher_2,
    input  logic [CIP_W-1:0]         i_cipher_3,
    input  logic [2:0]               i_row_code_0,
    input  logic [2:0]               i_row_code_1,
    input  logic [2:0]               i_row_code_2,
    input  logic [2:0]               i_row_code_3,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_plain_0,
    output logic signed [OUT_W-1:0]  o_plain_1,
    output logic signed [OUT_W-1:0]  o_plain_2,
    output logic signed [OUT_W-1:0]  o_plain_3,
    output logic                     o_singular
);

    logic                            f_valid;
    logic [DIM-1:0][DIVN_W-1:0]      f_divn;
    logic [DIVD_W-1:0]               f_divd;
    logic [DIM-1:0]                  f_neg;
    logic                            f_sing;
    logic [DIM-1:0]                  l_valid;
    logic [DIM-1:0]                  l_sing;
    logic signed [OUT_W-1:0]         l_plain [DIM];

    assign busy = 1'b0;

    mbcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_cipher   ({i_cipher_3, i_cipher_2, i_cipher_1, i_cipher_0}),
        .i_code     ({i_row_code_3, i_row_code_2, i_row_code_1, i_row_code_0}),
        .o_valid    (f_valid),
        .o_divn     (f_divn),
        .o_divd     (f_divd),
        .o_neg      (f_neg),
        .o_singular (f_sing)
    );

    // one divider lane per output word
    for (genvar g = 0; g < DIM; g++) begin : g_lane
        mbcd_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (f_valid),
            .i_divn     (f_divn[g]),
            .i_divd     (f_divd),
            .i_neg      (f_neg[g]),
            .i_singular (f_sing),
            .o_valid    (l_valid[g]),
            .o_plain    (l_plain[g]),
            .o_singular (l_sing[g])
        );
    end

    assign o_valid    = l_valid[0];
    assign o_singular = l_sing[0];
    assign o_plain_0  = l_plain[0];
    assign o_plain_1  = l_plain[1];
    assign o_plain_2  = l_plain[2];
    assign o_plain_3  = l_plain[3];

    // checks
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> (o_plain_0 == '0) && (o_plain_1 == '0)
                                  && (o_plain_2 == '0) && (o_plain_3 == '0))
        else $error("singular result with nonzero words");

    a_sing_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_singular |-> o_valid)
        else $error("singular flag without result strobe");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without matching start");

    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_valid == {DIM{l_valid[0]}})
        else $error("divider lanes out of step");

endmodule

[hw/rtl/mbcd_front.sv]
// Front end: key lookup, cofactors, products, determinant, divider operands.
// Four register stages; depends on mbcd_pkg.
module mbcd_front import mbcd_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [DIM-1:0][CIP_W-1:0]     i_cipher,
    input  logic [DIM-1:0][2:0]           i_code,
    output logic                          o_valid,
    output logic [DIM-1:0][DIVN_W-1:0]    o_divn,
    output logic [DIVD_W-1:0]             o_divd,
    output logic [DIM-1:0]                o_neg,
    output logic                          o_singular
);

    t_key                             key;
    logic                             r_v1, r_v2, r_v3, r_v4;
    t_cof                             r_cof [DIM][DIM];
    logic [DIM-1:0][CIP_W-1:0]        r_cip;
    logic [DIM-1:0][3:0]              r_k0;
    logic signed [PROD_W-1:0]         r_prod [DIM][DIM];
    logic signed [DET_W-1:0]          r_det2, r_det3;
    logic signed [NUM_W-1:0]          r_num [DIM];
    logic signed [DET_W-1:0]          n_det;
    logic signed [NUM_W-1:0]          n_num [DIM];
    logic [DIM-1:0][DIVN_W-1:0]       r_divn;
    logic [DIVD_W-1:0]                r_divd;
    logic [DIM-1:0]                   r_neg;
    logic                             r_sing;

    // key matrix from the digit table
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                key[r][c] = KEY_TABLE[i_code[r]][c];
            end
        end
    end

    // stage 1: cofactors
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                r_cof[r][c] <= cofactor(key, r, c);
            end
            r_k0[r] <= key[0][r];
        end
        r_cip <= i_cipher;
    end

    // stage 2: products and determinant
    always_comb begin
        n_det = '0;
        for (int c = 0; c < DIM; c++) begin
            n_det = n_det + DET_W'(signed'({1'b0, r_k0[c]})) * DET_W'(r_cof[0][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < DIM; c++) begin
            for (int h = 0; h < DIM; h++) begin
                r_prod[c][h] <= PROD_W'(signed'({1'b0, r_cip[h]})) * PROD_W'(r_cof[c][h]);
            end
        end
        r_det2 <= n_det;
    end

    // stage 3: numerator sums
    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            n_num[c] = '0;
            for (int h = 0; h < DIM; h++) begin
                n_num[c] = n_num[c] + NUM_W'(r_prod[c][h]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < DIM; c++) begin
            r_num[c] <= n_num[c];
        end
        r_det3 <= r_det2;
    end

    // stage 4: rounding operands, N = 2|num| + |det|, D = 2|det|
    always_ff @(posedge i_clk) begin
        logic [DET_W-1:0] ad;
        logic [NUM_W-1:0] an;
        ad = r_det3[DET_W-1] ? DET_W'(-r_det3) : DET_W'(r_det3);
        for (int c = 0; c < DIM; c++) begin
            an        = r_num[c][NUM_W-1] ? NUM_W'(-r_num[c]) : NUM_W'(r_num[c]);
            r_divn[c] <= DIVN_W'({an, 1'b0}) + DIVN_W'(ad);
            r_neg[c]  <= r_num[c][NUM_W-1] ^ r_det3[DET_W-1];
        end
        r_divd <= DIVD_W'({ad, 1'b0});
        r_sing <= (r_det3 == '0);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid    = r_v4;
    assign o_divn     = r_divn;
    assign o_divd     = r_divd;
    assign o_neg      = r_neg;
    assign o_singular = r_sing;

endmodule

[hw/rtl/mbcd_div.sv]
// One divider lane: pipelined restoring division, one quotient bit per stage,
// then sign, clamp and singular zeroing. Depends on mbcd_pkg.
module mbcd_div import mbcd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [DIVN_W-1:0]        i_divn,
    input  logic [DIVD_W-1:0]        i_divd,
    input  logic                     i_neg,
    input  logic                     i_singular,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_plain,
    output logic                     o_singular
);

    localparam int WIDE = DIVD_W + QB;

    logic                 r_v    [0:QB];
    logic [DIVN_W-1:0]    r_rem  [0:QB];
    logic [DIVD_W-1:0]    r_d    [0:QB];
    logic [QB-1:0]        r_q    [0:QB];
    logic                 r_ovf  [0:QB];
    logic                 r_neg  [0:QB];
    logic                 r_sing [0:QB];
    logic                 r_vo;
    logic signed [OUT_W-1:0] r_plain;
    logic                 r_so;

    // entry stage: overflow when quotient needs more than QB bits;
    // stage i resolves quotient bit QB-1-i
    always_ff @(posedge i_clk) begin
        logic [WIDE-1:0] sh;
        logic [WIDE-1:0] rem;
        r_rem[0]  <= i_divn;
        r_d[0]    <= i_divd;
        r_q[0]    <= '0;
        r_ovf[0]  <= WIDE'(i_divn) >= {i_divd, {QB{1'b0}}};
        r_neg[0]  <= i_neg;
        r_sing[0] <= i_singular;
        for (int i = 0; i < QB; i++) begin
            sh  = WIDE'(r_d[i]) << (QB - 1 - i);
            rem = WIDE'(r_rem[i]);
            if (rem >= sh) begin
                r_rem[i+1] <= DIVN_W'(rem - sh);
                r_q[i+1]   <= r_q[i] | (QB'(1) << (QB - 1 - i));
            end else begin
                r_rem[i+1] <= r_rem[i];
                r_q[i+1]   <= r_q[i];
            end
            r_d[i+1]    <= r_d[i];
            r_ovf[i+1]  <= r_ovf[i];
            r_neg[i+1]  <= r_neg[i];
            r_sing[i+1] <= r_sing[i];
        end
    end

    // output stage: singular zeroing, sign and clamp to 16 bits
    always_ff @(posedge i_clk) begin
        logic big_pos;
        logic big_neg;
        big_pos = r_ovf[QB] || (r_q[QB] > QB'(32767));
        big_neg = r_ovf[QB] || (r_q[QB] > QB'(32768));
        if (r_sing[QB]) begin
            r_plain <= '0;
        end else if (r_neg[QB]) begin
            r_plain <= big_neg ? OUT_W'(16'sh8000) : OUT_W'(-r_q[QB]);
        end else begin
            r_plain <= big_pos ? OUT_W'(16'sh7FFF) : OUT_W'(r_q[QB]);
        end
        r_so <= r_sing[QB] && r_v[QB];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QB; i++) begin
                r_v[i] <= 1'b0;
            end
            r_vo <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int i = 0; i < QB; i++) begin
                r_v[i+1] <= r_v[i];
            end
            r_vo <= r_v[QB];
        end
    end

    assign o_valid    = r_vo;
    assign o_plain    = r_plain;
    assign o_singular = r_so;

endmodule

[bench/tb_matrix_block_cipher_decode_top.sv]
// Testbench for the 4x4 matrix block decoder: directed table then random blocks.
// Depends on mbcd_pkg and matrix_block_cipher_decode_top; self-checking predictor.
module tb_matrix_block_cipher_decode_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mbcd_pkg::*;

    typedef struct {
        logic [CIP_W-1:0] cip [4];
        logic [2:0]       code [4];
    } t_block;

    typedef struct {
        logic signed [OUT_W-1:0] plain [4];
        logic                    singular;
    } t_plain;

    typedef struct {
        t_block blk;
        bit     fixed;    // expected result typed in
        t_plain want;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [CIP_W-1:0]        cip_d [4];
    logic [2:0]              code_d [4];
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_plain_0, o_plain_1, o_plain_2, o_plain_3;
    logic                    o_singular;

    t_plain plain_queue [$];
    int     mismatches;
    bit     stim_done;

    // digit table held locally, rows as in the package KEY_TABLE
    const int digits [8][4] = '{
        '{8, 1, 8, 9}, '{5, 5, 0, 9}, '{6, 3, 3, 1}, '{5, 4, 5, 4},
        '{8, 0, 4, 3}, '{8, 9, 9, 0}, '{1, 9, 7, 2}, '{0, 7, 3, 4}
    };

    matrix_block_cipher_decode_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cipher_0(cip_d[0]), .i_cipher_1(cip_d[1]),
        .i_cipher_2(cip_d[2]), .i_cipher_3(cip_d[3]),
        .i_row_code_0(code_d[0]), .i_row_code_1(code_d[1]),
        .i_row_code_2(code_d[2]), .i_row_code_3(code_d[3]),
        .o_valid(o_valid), .o_plain_0(o_plain_0), .o_plain_1(o_plain_1),
        .o_plain_2(o_plain_2), .o_plain_3(o_plain_3), .o_singular(o_singular)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // 3x3 minor with one row and column struck out
    function automatic longint minor_of(input longint k [4][4], input int sr, input int sc);
        longint s [3][3];
        int     a;
        int     b;
        a = 0;
        for (int r = 0; r < 4; r++) begin
            if (r != sr) begin
                b = 0;
                for (int c = 0; c < 4; c++) begin
                    if (c != sc) begin
                        s[a][b] = k[r][c];
                        b++;
                    end
                end
                a++;
            end
        end
        return s[0][0] * (s[1][1] * s[2][2] - s[2][1] * s[1][2])
             - s[0][1] * (s[1][0] * s[2][2] - s[2][0] * s[1][2])
             + s[0][2] * (s[1][0] * s[2][1] - s[2][0] * s[1][1]);
    endfunction

    // decrypt one block: adjugate product over determinant, rounded, clamped
    function automatic t_plain decode_block(input t_block blk);
        longint k [4][4];
        longint cof [4][4];
        longint det;
        longint num;
        longint an;
        longint ad;
        longint q;
        t_plain res;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                k[r][c] = digits[blk.code[r]][c];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                cof[r][c] = ((r + c) % 2) ? -minor_of(k, r, c) : minor_of(k, r, c);
        det = 0;
        for (int c = 0; c < 4; c++) det += k[0][c] * cof[0][c];
        res.singular = (det == 0);
        for (int j = 0; j < 4; j++) begin
            res.plain[j] = '0;
            if (det != 0) begin
                num = 0;
                for (int h = 0; h < 4; h++) num += longint'(blk.cip[h]) * cof[j][h];
                an = num < 0 ? -num : num;
                ad = det < 0 ? -det : det;
                q = (2 * an + ad) / (2 * ad);
                if ((num < 0) != (det < 0)) q = -q;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                res.plain[j] = q[OUT_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic t_block make_block(input int c0, c1, c2, c3, input int r0, r1, r2, r3);
        t_block b;
        b.cip[0] = CIP_W'(c0); b.cip[1] = CIP_W'(c1);
        b.cip[2] = CIP_W'(c2); b.cip[3] = CIP_W'(c3);
        b.code[0] = 3'(r0); b.code[1] = 3'(r1); b.code[2] = 3'(r2); b.code[3] = 3'(r3);
        return b;
    endfunction

    function automatic t_block rand_block();
        t_block     b;
        logic [1:0] dup;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 9))
                0: b.cip[i] = CIP_W'($urandom_range(0, 16383));
                1: b.cip[i] = ($urandom_range(0, 1) != 0) ? 14'h3fff : 14'h0;
                default: b.cip[i] = CIP_W'($urandom_range(0, 9180));
            endcase
            b.code[i] = 3'($urandom_range(0, 7));
        end
        // sometimes repeat a row for a singular key
        dup = 2'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) b.code[dup] = b.code[0];
        return b;
    endfunction

    // present one block; hold start through acceptance, sometimes an idle gap after
    task automatic send_block(input t_block blk, input bit fixed, input t_plain want);
        int gap;
        start <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cip_d[i]  <= blk.cip[i];
            code_d[i] <= blk.code[i];
        end
        do @(posedge i_clk); while (busy);
        plain_queue.push_back(fixed ? want : decode_block(blk));
        case ($urandom_range(0, 19))
            0:             gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            default:       gap = 0;
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_plain want;
        logic signed [OUT_W-1:0] got [4];
        bit bad;
        if (i_rst_n && o_valid) begin
            got[0] = o_plain_0; got[1] = o_plain_1; got[2] = o_plain_2; got[3] = o_plain_3;
            if (plain_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                want = plain_queue.pop_front();
                bad  = (o_singular !== want.singular);
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want.plain[i]) bad = 1'b1;
                end
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %0d %0d %0d %0d s%0b got %0d %0d %0d %0d s%0b",
                                 want.plain[0], want.plain[1], want.plain[2], want.plain[3],
                                 want.singular, got[0], got[1], got[2], got[3], o_singular);
                end
            end
        end
    end

    initial begin
        t_row   rows [$];
        t_row   row;
        t_plain zero_sing;
        t_plain zero_reg;
        int     waited;
        mismatches = 0;
        stim_done  = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        for (int i = 0; i < 4; i++) begin
            cip_d[i]  = '0;
            code_d[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            zero_sing.plain[i] = '0;
            zero_reg.plain[i]  = '0;
        end
        zero_sing.singular = 1'b1;
        zero_reg.singular  = 1'b0;

        // directed rows: repeated codes are singular, zero cipher is zero
        row.fixed = 1; row.want = zero_sing;
        row.blk = make_block(0, 0, 0, 0, 0, 0, 0, 0);                 rows.push_back(row);
        row.blk = make_block(16383, 16383, 16383, 16383, 7, 7, 7, 7); rows.push_back(row);
        row.blk = make_block(9180, 1, 2, 3, 0, 1, 2, 0);              rows.push_back(row);
        row.blk = make_block(5, 9180, 16383, 0, 3, 3, 4, 5);          rows.push_back(row);
        row.want = zero_reg;
        row.blk = make_block(0, 0, 0, 0, 0, 1, 2, 3);                 rows.push_back(row);
        row.blk = make_block(0, 0, 0, 0, 4, 5, 6, 7);                 rows.push_back(row);
        // predictor rows: extremes, halves, saturation
        row.fixed = 0;
        row.blk = make_block(16383, 16383, 16383, 16383, 0, 1, 2, 3); rows.push_back(row);
        row.blk = make_block(16383, 0, 16383, 0, 4, 5, 6, 7);         rows.push_back(row);
        row.blk = make_block(0, 16383, 0, 16383, 7, 6, 5, 4);         rows.push_back(row);
        row.blk = make_block(9180, 9180, 9180, 9180, 3, 2, 1, 0);     rows.push_back(row);
        row.blk = make_block(1, 0, 0, 0, 0, 1, 2, 3);                 rows.push_back(row);
        row.blk = make_block(0, 0, 0, 1, 1, 2, 3, 4);                 rows.push_back(row);
        row.blk = make_block(10922, 5461, 16383, 0, 2, 4, 6, 0);      rows.push_back(row);
        row.blk = make_block(8191, 8192, 4095, 12288, 1, 3, 5, 7);    rows.push_back(row);
        row.blk = make_block(16383, 0, 0, 0, 6, 7, 0, 1);             rows.push_back(row);
        row.blk = make_block(0, 0, 16383, 0, 5, 0, 3, 6);             rows.push_back(row);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) send_block(rows[n].blk, rows[n].fixed, rows[n].want);
        for (int n = 0; n < 1550; n++) send_block(rand_block(), 0, zero_reg);
        start <= 1'b0;

        // drain, then let the pipe settle
        waited = 0;
        while (plain_queue.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (plain_queue.size() != 0 || mismatches != 0) begin
            $display("Simulation FAILED");
        end else begin
            $display("Simulation PASSED");
        end
        $finish;
    end
endmodule

[sim.f]
hw/rtl/mbcd_pkg.sv
hw/rtl/mbcd_front.sv
hw/rtl/mbcd_div.sv
hw/rtl/matrix_block_cipher_decode_top.sv
bench/tb_matrix_block_cipher_decode_top.sv
